### src/tbrl_pkg.sv
// Shared types and constants for the token bucket rate limiter.
// Used by every module in src; has no dependencies of its own.
package tbrl_pkg;

    // Field and register widths.
    localparam int unsigned NOW_W     = 63;
    localparam int unsigned AMT_W     = 32;
    localparam int unsigned RATE_W    = 32;
    localparam int unsigned BURST_W   = 32;
    localparam int unsigned TCAP_W    = 48;
    localparam int unsigned CFG_W     = 48;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned WAIT_W    = 32;
    localparam int unsigned TOT_W     = 64;
    localparam int unsigned BAL_W     = 64;
    localparam int unsigned MICRO_W   = 20;
    localparam int unsigned AMTM_W    = AMT_W + MICRO_W;

    // Default depth of the queue between front and back.
    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    // One token is this many micro-tokens.
    localparam logic [MICRO_W-1:0] MICRO_PER_TOKEN = 20'd1000000;

    // Saturation limits of the balance.
    localparam logic signed [BAL_W-1:0] BAL_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [BAL_W-1:0] BAL_MIN = 64'sh8000_0000_0000_0000;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_RATE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BURST     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_CAP = 2'd2;

    // Classified item handed from the front to the back.
    typedef struct packed {
        logic               rejected;
        logic               need_div;
        logic [BAL_W-1:0]   deficit;
        logic [RATE_W-1:0]  rate;
        logic [TOT_W-1:0]   total;
    } t_job;

    typedef enum logic [3:0] {
        F_IDLE,
        F_MAG,
        F_MUL_LO,
        F_MUL_HI,
        F_SUM,
        F_GAIN,
        F_ADD_GAIN,
        F_ADD_AMT,
        F_CAP,
        F_PUSH
    } t_front_state;

    typedef enum logic [1:0] {
        B_IDLE,
        B_DIV,
        B_DONE
    } t_back_state;

endpackage

### src/tbrl_front.sv
// Front of the rate limiter: configuration registers, item intake, balance
// and total update, and classification into jobs. Depends on tbrl_pkg.
module tbrl_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [tbrl_pkg::NOW_W-1:0]         i_now_us,
    input  logic [tbrl_pkg::AMT_W-1:0]         i_amount,
    input  logic                               i_cfg_we,
    input  logic [tbrl_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [tbrl_pkg::CFG_W-1:0]         i_cfg_data,
    output logic                               o_push,
    output tbrl_pkg::t_job                     o_job,
    input  logic                               i_full
);

    tbrl_pkg::t_front_state r_state, n_state;

    logic [tbrl_pkg::RATE_W-1:0]          r_rate;
    logic [tbrl_pkg::BURST_W-1:0]         r_burst;
    logic [tbrl_pkg::TCAP_W-1:0]          r_tcap;

    logic signed [tbrl_pkg::BAL_W-1:0]    r_balance;
    logic [tbrl_pkg::NOW_W-1:0]           r_last;
    logic [tbrl_pkg::TOT_W-1:0]           r_total;

    logic [tbrl_pkg::AMT_W-1:0]           r_amt;
    logic signed [tbrl_pkg::BAL_W-1:0]    r_diff;
    logic                                 r_neg;
    logic [tbrl_pkg::NOW_W-1:0]           r_mag;
    logic [tbrl_pkg::AMTM_W-1:0]          r_amt_micro;
    logic [tbrl_pkg::AMTM_W-1:0]          r_cap_micro;
    logic [63:0]                          r_p_lo;
    logic [62:0]                          r_p_hi;
    logic [94:0]                          r_prod;
    logic signed [tbrl_pkg::BAL_W-1:0]    r_gain;

    logic                                 w_accept;
    logic [tbrl_pkg::TOT_W:0]             w_total_sum;
    logic signed [tbrl_pkg::BAL_W-1:0]    w_diff;
    logic signed [tbrl_pkg::BAL_W-1:0]    w_diff_neg;
    logic signed [tbrl_pkg::BAL_W-1:0]    w_mag_wide;
    logic signed [tbrl_pkg::BAL_W-1:0]    w_neg_amt;
    logic signed [tbrl_pkg::BAL_W-1:0]    w_cap_wide;
    logic                                 w_rejected;

    // Signed add that sticks at the 64-bit limits.
    function automatic logic signed [63:0] f_sat_add(
        input logic signed [63:0] a,
        input logic signed [63:0] b
    );
        logic signed [63:0] s;
        begin
            s = a + b;
            if (!a[63] && !b[63] && s[63]) begin
                return tbrl_pkg::BAL_MAX;
            end else if (a[63] && b[63] && !s[63]) begin
                return tbrl_pkg::BAL_MIN;
            end
            return s;
        end
    endfunction

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tbrl_pkg::F_IDLE: begin
                if (i_valid) begin
                    n_state = (r_rate != '0) ? tbrl_pkg::F_MAG : tbrl_pkg::F_PUSH;
                end
            end
            tbrl_pkg::F_MAG:      n_state = tbrl_pkg::F_MUL_LO;
            tbrl_pkg::F_MUL_LO:   n_state = tbrl_pkg::F_MUL_HI;
            tbrl_pkg::F_MUL_HI:   n_state = tbrl_pkg::F_SUM;
            tbrl_pkg::F_SUM:      n_state = tbrl_pkg::F_GAIN;
            tbrl_pkg::F_GAIN:     n_state = tbrl_pkg::F_ADD_GAIN;
            tbrl_pkg::F_ADD_GAIN: n_state = tbrl_pkg::F_ADD_AMT;
            tbrl_pkg::F_ADD_AMT:  n_state = tbrl_pkg::F_CAP;
            tbrl_pkg::F_CAP:      n_state = tbrl_pkg::F_PUSH;
            tbrl_pkg::F_PUSH: begin
                if (!i_full) begin
                    n_state = tbrl_pkg::F_IDLE;
                end
            end
            default:              n_state = tbrl_pkg::F_IDLE;
        endcase
    end

    // Handshake outputs.
    always_comb begin
        o_stall = 1'b1;
        o_push  = 1'b0;
        unique case (r_state)
            tbrl_pkg::F_IDLE: o_stall = 1'b0;
            tbrl_pkg::F_PUSH: o_push  = !i_full;
            default: begin
                o_stall = 1'b1;
            end
        endcase
    end

    assign w_accept = i_valid && (r_state == tbrl_pkg::F_IDLE);

    // Intake arithmetic: saturating total and signed elapsed time.
    assign w_total_sum = {1'b0, r_total} + {33'd0, i_amount};
    assign w_diff      = $signed({1'b0, i_now_us}) - $signed({1'b0, r_last});
    assign w_diff_neg  = 64'sd0 - r_diff;
    assign w_mag_wide  = r_diff[63] ? w_diff_neg : r_diff;
    assign w_neg_amt   = 64'sd0 - $signed({12'd0, r_amt_micro});
    assign w_cap_wide  = $signed({12'd0, r_cap_micro});

    // Classification of the finished item.
    assign w_rejected = (r_tcap != '0) && (r_total > {16'd0, r_tcap});
    always_comb begin
        o_job.rejected = w_rejected;
        o_job.need_div = !w_rejected && (r_rate != '0) && r_balance[63];
        o_job.deficit  = 64'd0 - r_balance;
        o_job.rate     = r_rate;
        o_job.total    = r_total;
    end

    // Control state and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= tbrl_pkg::F_IDLE;
            r_rate    <= '0;
            r_burst   <= '0;
            r_tcap    <= '0;
            r_balance <= '0;
            r_last    <= '0;
            r_total   <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    tbrl_pkg::CFG_RATE:      r_rate  <= i_cfg_data[tbrl_pkg::RATE_W-1:0];
                    tbrl_pkg::CFG_BURST:     r_burst <= i_cfg_data[tbrl_pkg::BURST_W-1:0];
                    tbrl_pkg::CFG_TOTAL_CAP: r_tcap  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (w_accept) begin
                r_last  <= i_now_us;
                r_total <= w_total_sum[tbrl_pkg::TOT_W] ? '1 : w_total_sum[tbrl_pkg::TOT_W-1:0];
            end
            // Balance update steps.
            if (r_state == tbrl_pkg::F_ADD_GAIN) begin
                r_balance <= f_sat_add(r_balance, r_gain);
            end else if (r_state == tbrl_pkg::F_ADD_AMT) begin
                r_balance <= f_sat_add(r_balance, w_neg_amt);
            end else if (r_state == tbrl_pkg::F_CAP && r_balance > w_cap_wide) begin
                r_balance <= w_cap_wide;
            end
        end
    end

    // Datapath: elapsed-time product in two halves, then saturation.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_amt  <= i_amount;
            r_diff <= w_diff;
        end
        unique case (r_state)
            tbrl_pkg::F_MAG: begin
                r_neg       <= r_diff[63];
                r_mag       <= w_mag_wide[tbrl_pkg::NOW_W-1:0];
                r_amt_micro <= r_amt * tbrl_pkg::MICRO_PER_TOKEN;
            end
            tbrl_pkg::F_MUL_LO: begin
                r_p_lo      <= r_mag[31:0] * r_rate;
                r_cap_micro <= r_burst * tbrl_pkg::MICRO_PER_TOKEN;
            end
            tbrl_pkg::F_MUL_HI: begin
                r_p_hi <= r_mag[62:32] * r_rate;
            end
            tbrl_pkg::F_SUM: begin
                r_prod <= {r_p_hi, 32'd0} + {31'd0, r_p_lo};
            end
            tbrl_pkg::F_GAIN: begin
                if (|r_prod[94:63]) begin
                    r_gain <= r_neg ? tbrl_pkg::BAL_MIN : tbrl_pkg::BAL_MAX;
                end else if (r_neg) begin
                    r_gain <= 64'sd0 - $signed({1'b0, r_prod[62:0]});
                end else begin
                    r_gain <= $signed({1'b0, r_prod[62:0]});
                end
            end
            default: begin
            end
        endcase
    end

endmodule

### src/tbrl_fifo.sv
// Short queue of classified jobs between the front and the back.
// Depends on tbrl_pkg for the job type.
module tbrl_fifo #(
    parameter int unsigned DEPTH = tbrl_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tbrl_pkg::t_job  i_job,
    output logic            o_full,
    input  logic            i_pop,
    output tbrl_pkg::t_job  o_job,
    output logic            o_empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    tbrl_pkg::t_job    r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### src/tbrl_back.sv
// Back of the rate limiter: bit-serial division of the deficit by the rate
// and the registered result stage. Depends on tbrl_pkg.
module tbrl_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_empty,
    input  tbrl_pkg::t_job                  i_job,
    output logic                            o_pop,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic                            o_rejected,
    output logic [tbrl_pkg::WAIT_W-1:0]     o_wait_us,
    output logic [tbrl_pkg::TOT_W-1:0]      o_running_total
);

    tbrl_pkg::t_back_state r_state, n_state;

    logic [tbrl_pkg::RATE_W-1:0]   r_rem;
    logic [tbrl_pkg::BAL_W-1:0]    r_quo;
    logic [tbrl_pkg::RATE_W-1:0]   r_div;
    logic [5:0]                    r_step;
    logic [tbrl_pkg::TOT_W-1:0]    r_total_hold;

    logic                          r_out_valid;
    logic                          r_out_rej;
    logic [tbrl_pkg::WAIT_W-1:0]   r_out_wait;
    logic [tbrl_pkg::TOT_W-1:0]    r_out_total;

    logic                          w_out_free;
    logic                          w_load;
    logic [tbrl_pkg::RATE_W:0]     w_shift;
    logic                          w_ge;
    logic [tbrl_pkg::RATE_W:0]     w_sub;
    logic [tbrl_pkg::WAIT_W-1:0]   w_wait;

    assign w_out_free = !r_out_valid || !i_stall;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tbrl_pkg::B_IDLE: begin
                if (o_pop && i_job.need_div) begin
                    n_state = tbrl_pkg::B_DIV;
                end
            end
            tbrl_pkg::B_DIV: begin
                if (r_step == 6'd63) begin
                    n_state = tbrl_pkg::B_DONE;
                end
            end
            tbrl_pkg::B_DONE: begin
                if (w_out_free) begin
                    n_state = tbrl_pkg::B_IDLE;
                end
            end
            default: n_state = tbrl_pkg::B_IDLE;
        endcase
    end

    // Queue pop and result load.
    always_comb begin
        o_pop  = 1'b0;
        w_load = 1'b0;
        unique case (r_state)
            tbrl_pkg::B_IDLE: begin
                o_pop  = !i_empty && (i_job.need_div || w_out_free);
                w_load = !i_empty && !i_job.need_div && w_out_free;
            end
            tbrl_pkg::B_DONE: begin
                w_load = w_out_free;
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    // One restoring division step; the remainder stays below the divisor.
    assign w_shift = {r_rem, r_quo[63]};
    assign w_ge    = (w_shift >= {1'b0, r_div});
    assign w_sub   = w_shift - {1'b0, r_div};
    assign w_wait  = (|r_quo[63:32]) ? '1 : r_quo[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tbrl_pkg::B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Divider and result registers.
    always_ff @(posedge i_clk) begin
        if (r_state == tbrl_pkg::B_IDLE && o_pop) begin
            r_rem        <= '0;
            r_quo        <= i_job.deficit;
            r_div        <= i_job.rate;
            r_step       <= '0;
            r_total_hold <= i_job.total;
        end else if (r_state == tbrl_pkg::B_DIV) begin
            r_rem  <= w_ge ? w_sub[tbrl_pkg::RATE_W-1:0] : w_shift[tbrl_pkg::RATE_W-1:0];
            r_quo  <= {r_quo[62:0], w_ge};
            r_step <= r_step + 1'b1;
        end
        if (w_load) begin
            if (r_state == tbrl_pkg::B_DONE) begin
                r_out_rej   <= 1'b0;
                r_out_wait  <= w_wait;
                r_out_total <= r_total_hold;
            end else begin
                r_out_rej   <= i_job.rejected;
                r_out_wait  <= '0;
                r_out_total <= i_job.total;
            end
        end
    end

    assign o_valid         = r_out_valid;
    assign o_rejected      = r_out_rej;
    assign o_wait_us       = r_out_wait;
    assign o_running_total = r_out_total;

    // A rejected item never carries a delay.
    a_rej_no_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rejected |-> o_wait_us == '0)
        else $error("rejected item with nonzero wait");

    // The divider only runs with a nonzero divisor.
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == tbrl_pkg::B_DIV |-> r_div != '0)
        else $error("division by zero rate");

    // The last division step hands over to the result stage.
    a_div_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == tbrl_pkg::B_DIV && r_step == 6'd63 |=> r_state == tbrl_pkg::B_DONE)
        else $error("divider overran its step count");

endmodule

### src/token_bucket_rate_limiter.sv
// Token bucket rate limiter: each item carries a time stamp in microseconds
// and a token amount and yields one result with a reject flag, a delay and the
// running total. The front takes an item and then steps through the balance
// update, which it skips when the rate is zero; the back passes an item without a
// delay on to its result stage and runs an item with a negative balance through
// the bit-serial 64-bit by 32-bit divider. A queue of QUEUE_DEPTH items lets the
// front keep working while the divider runs.
// Depends on tbrl_pkg, tbrl_front, tbrl_fifo and tbrl_back.
module token_bucket_rate_limiter #(
    parameter int unsigned QUEUE_DEPTH = tbrl_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [tbrl_pkg::NOW_W-1:0]         i_now_us,
    input  logic [tbrl_pkg::AMT_W-1:0]         i_amount,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic                               o_rejected,
    output logic [tbrl_pkg::WAIT_W-1:0]        o_wait_us,
    output logic [tbrl_pkg::TOT_W-1:0]         o_running_total,
    input  logic                               i_cfg_we,
    input  logic [tbrl_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [tbrl_pkg::CFG_W-1:0]         i_cfg_data
);

    logic            w_push;
    logic            w_full;
    logic            w_pop;
    logic            w_empty;
    tbrl_pkg::t_job  w_job_in;
    tbrl_pkg::t_job  w_job_out;

    // Intake and balance update.
    tbrl_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_now_us   (i_now_us),
        .i_amount   (i_amount),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_push     (w_push),
        .o_job      (w_job_in),
        .i_full     (w_full)
    );

    // Job queue.
    tbrl_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_job   (w_job_out),
        .o_empty (w_empty)
    );

    // Delay computation and result stage.
    tbrl_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_empty         (w_empty),
        .i_job           (w_job_out),
        .o_pop           (w_pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_rejected      (o_rejected),
        .o_wait_us       (o_wait_us),
        .o_running_total (o_running_total)
    );

endmodule

### sim/token_bucket_rate_limiter_checker.sv
`timescale 1ns / 100ps
// Checker for the token bucket rate limiter: watches the request, result and
// register ports, keeps its own account of the bucket and compares every result.
// Depends on tbrl_pkg for widths, limits and register indexes.
module token_bucket_rate_limiter_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic [tbrl_pkg::NOW_W-1:0]     i_now_us,
    input  logic [tbrl_pkg::AMT_W-1:0]     i_amount,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic                           i_rejected,
    input  logic [tbrl_pkg::WAIT_W-1:0]    i_wait_us,
    input  logic [tbrl_pkg::TOT_W-1:0]     i_running_total,
    input  logic                           i_cfg_we,
    input  logic [tbrl_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tbrl_pkg::CFG_W-1:0]     i_cfg_data,
    output int                             o_mismatches,
    output int                             o_pending,
    output int                             o_results,
    output int                             o_delayed,
    output int                             o_rejects
);

    typedef struct packed {
        logic                        rejected;
        logic [tbrl_pkg::WAIT_W-1:0] wait_us;
        logic [tbrl_pkg::TOT_W-1:0]  running_total;
    } t_outcome;

    // Outcomes of accepted requests, oldest first.
    t_outcome outcome_q[$];

    // Register copies.
    logic [tbrl_pkg::RATE_W-1:0]  rate;
    logic [tbrl_pkg::BURST_W-1:0] burst;
    logic [tbrl_pkg::TCAP_W-1:0]  total_cap;

    // Bucket state.
    logic signed [tbrl_pkg::BAL_W-1:0] balance;
    logic [tbrl_pkg::NOW_W-1:0]        last_stamp;
    logic [tbrl_pkg::TOT_W-1:0]        amount_sum;

    int mismatches;
    int results;
    int delayed;
    int rejects;

    // Saturate a wide signed value to the 64-bit balance range.
    function automatic logic signed [tbrl_pkg::BAL_W-1:0] clamp_balance(
        input logic signed [129:0] v
    );
        if (v > tbrl_pkg::BAL_MAX) return tbrl_pkg::BAL_MAX;
        if (v < tbrl_pkg::BAL_MIN) return tbrl_pkg::BAL_MIN;
        return v[tbrl_pkg::BAL_W-1:0];
    endfunction

    // Update the bucket for one request and return the result it should produce.
    function automatic t_outcome account_request(input logic [tbrl_pkg::NOW_W-1:0] now,
                                                 input logic [tbrl_pkg::AMT_W-1:0] amt);
        logic signed [129:0]               elapsed;
        logic signed [129:0]               product;
        logic signed [tbrl_pkg::BAL_W-1:0] gain;
        logic [63:0]                       debit;
        logic [63:0]                       cap;
        logic [64:0]                       sum;
        logic [63:0]                       deficit;
        logic [63:0]                       quotient;
        t_outcome                          res;
        res = '0;

        // The balance only moves while a refill rate is set. The gain saturates
        // on its own before it is added to the balance.
        if (rate != 0) begin
            elapsed = $signed({67'd0, now}) - $signed({67'd0, last_stamp});
            product = elapsed * $signed({98'd0, rate});
            gain    = clamp_balance(product);
            balance = clamp_balance(gain + balance);
            debit   = 64'(amt) * 64'(tbrl_pkg::MICRO_PER_TOKEN);
            balance = clamp_balance(balance - $signed({66'd0, debit}));
            cap     = 64'(burst) * 64'(tbrl_pkg::MICRO_PER_TOKEN);
            if (balance > $signed(cap)) balance = $signed(cap);
        end

        // The running total sticks at its maximum.
        sum        = {1'b0, amount_sum} + 65'(amt);
        amount_sum = sum[64] ? '1 : sum[63:0];
        last_stamp = now;
        res.running_total = amount_sum;

        // A rejection overrides any delay; the most negative balance has magnitude 2^63.
        if (total_cap != 0 && amount_sum > 64'(total_cap)) begin
            res.rejected = 1'b1;
        end else if (rate != 0 && balance < 0) begin
            deficit     = 64'd0 - balance;
            quotient    = deficit / 64'(rate);
            res.wait_us = (quotient > 64'hFFFF_FFFF) ? '1 : quotient[tbrl_pkg::WAIT_W-1:0];
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_outcome got;
        t_outcome want;
        got = '{rejected: i_rejected, wait_us: i_wait_us,
                running_total: i_running_total};
        if (!i_rst_n) begin
            rate       = '0;
            burst      = '0;
            total_cap  = '0;
            balance    = '0;
            last_stamp = '0;
            amount_sum = '0;
            outcome_q.delete();
        end else begin
            // Register writes land before any item of the same edge.
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    tbrl_pkg::CFG_RATE:      rate      = i_cfg_data[tbrl_pkg::RATE_W-1:0];
                    tbrl_pkg::CFG_BURST:     burst     = i_cfg_data[tbrl_pkg::BURST_W-1:0];
                    tbrl_pkg::CFG_TOTAL_CAP: total_cap = i_cfg_data[tbrl_pkg::TCAP_W-1:0];
                    default: ;
                endcase
            end

            if (i_in_valid && !i_in_stall) begin
                outcome_q.push_back(account_request(i_now_us, i_amount));
            end

            // Compare each result against the oldest outstanding outcome.
            if (i_out_valid && !i_out_stall) begin
                results++;
                if (i_wait_us != 0) delayed++;
                if (i_rejected) rejects++;
                if (outcome_q.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("%0t: result with no request outstanding:", $time);
                        $display("%0t:   got rejected=%0b wait=%0d total=%0d",
                                 $time, got.rejected, got.wait_us, got.running_total);
                    end
                    mismatches++;
                end else begin
                    want = outcome_q.pop_front();
                    if (got.rejected !== want.rejected || got.wait_us !== want.wait_us ||
                        got.running_total !== want.running_total) begin
                        if (mismatches < 10) begin
                            $display("%0t: result %0d differs: expected rejected=%0b",
                                     $time, results, want.rejected);
                            $display("%0t:   expected wait=%0d total=%0d",
                                     $time, want.wait_us, want.running_total);
                            $display("%0t:   got rejected=%0b wait=%0d total=%0d",
                                     $time, got.rejected, got.wait_us, got.running_total);
                        end
                        mismatches++;
                    end
                end
            end
        end
        o_pending    <= outcome_q.size();
        o_mismatches <= mismatches;
        o_results    <= results;
        o_delayed    <= delayed;
        o_rejects    <= rejects;
    end

endmodule

### sim/token_bucket_rate_limiter_tb.sv
`timescale 1ns / 100ps
// Top of the rate limiter testbench: clock, reset, register settings, request
// stimulus and random stalls. Depends on tbrl_pkg, the block and the checker.
module token_bucket_rate_limiter_tb;

    localparam int STALL_LIMIT    = 3000;
    localparam int PHASES         = 9;
    localparam int PHASE_ITEMS    = 110;
    localparam int PRESSURE_PHASE = 4;
    localparam int TAIL_CYCLES    = 100;

    // Index past the last register; writes to it must do nothing.
    localparam logic [tbrl_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    localparam logic [tbrl_pkg::NOW_W-1:0]   NOW_MAX   = '1;
    localparam logic [tbrl_pkg::AMT_W-1:0]   AMT_MAX   = '1;
    localparam logic [tbrl_pkg::RATE_W-1:0]  RATE_MAX  = '1;
    localparam logic [tbrl_pkg::BURST_W-1:0] BURST_MAX = '1;
    localparam logic [tbrl_pkg::TCAP_W-1:0]  TCAP_MAX  = '1;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           tx_valid  = 1'b0;
    logic [tbrl_pkg::NOW_W-1:0]     tx_now    = '0;
    logic [tbrl_pkg::AMT_W-1:0]     tx_amount = '0;
    logic                           rx_stall  = 1'b0;
    logic                           cfg_we    = 1'b0;
    logic [tbrl_pkg::CFG_IDX_W-1:0] cfg_idx   = tbrl_pkg::CFG_RATE;
    logic [tbrl_pkg::CFG_W-1:0]     cfg_data  = '0;
    logic                           dut_stall;
    logic                           out_valid;
    logic                           rejected;
    logic [tbrl_pkg::WAIT_W-1:0]    wait_us;
    logic [tbrl_pkg::TOT_W-1:0]     running_total;

    int mismatches;
    int pending;
    int results;
    int delayed;
    int rejects;

    // Stimulus controls and counters; some are shared with the receiver process.
    bit                         calm_tail   = 1'b0;
    bit                         hold_req    = 1'b0;
    int                         hold_len    = 0;
    int                         tx_idle_pct = 30;
    int                         rx_idle_pct = 10;
    logic [tbrl_pkg::NOW_W-1:0] stamp       = '0;
    logic [tbrl_pkg::TOT_W-1:0] last_total  = '0;
    int                         items_sent  = 0;
    int                         settings    = 0;

    token_bucket_rate_limiter u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_valid         (tx_valid),
        .o_stall         (dut_stall),
        .i_now_us        (tx_now),
        .i_amount        (tx_amount),
        .o_valid         (out_valid),
        .i_stall         (rx_stall),
        .o_rejected      (rejected),
        .o_wait_us       (wait_us),
        .o_running_total (running_total),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    token_bucket_rate_limiter_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (tx_valid),
        .i_in_stall      (dut_stall),
        .i_now_us        (tx_now),
        .i_amount        (tx_amount),
        .i_out_valid     (out_valid),
        .i_out_stall     (rx_stall),
        .i_rejected      (rejected),
        .i_wait_us       (wait_us),
        .i_running_total (running_total),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .o_mismatches    (mismatches),
        .o_pending       (pending),
        .o_results       (results),
        .o_delayed       (delayed),
        .o_rejects       (rejects)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // The latest running total seen is used to place the total cap.
    always @(posedge clk) begin
        if (out_valid && !rx_stall) last_total <= running_total;
    end

    // Receiver: random stall bursts, plus one long hold-off when asked.
    initial begin
        forever begin
            @(posedge clk);
            if (hold_req) begin
                rx_stall <= 1'b1;
                repeat (hold_len) @(posedge clk);
                hold_req = 1'b0;
                rx_stall <= 1'b0;
            end else if (!calm_tail && $urandom_range(0, 99) < rx_idle_pct) begin
                rx_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge clk);
                rx_stall <= 1'b0;
            end
        end
    end

    // Watchdog: ends the run when nothing moves for too long.
    initial begin : watchdog
        int still_cycles;
        still_cycles = 0;
        while (still_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((tx_valid && !dut_stall) || (out_valid && !rx_stall) || cfg_we || !rst_n)
                still_cycles = 0;
            else
                still_cycles++;
        end
        $display("Timeout: no item moved for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, pending);
        $display("Verification failed");
        $finish;
    end

    // Offer one request, after an optional idle burst, and wait until it is taken.
    task automatic send_item(input logic [tbrl_pkg::NOW_W-1:0] t,
                             input logic [tbrl_pkg::AMT_W-1:0] a);
        if (!calm_tail && $urandom_range(0, 99) < tx_idle_pct) begin
            tx_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        tx_valid  <= 1'b1;
        tx_now    <= t;
        tx_amount <= a;
        do @(posedge clk); while (dut_stall);
        items_sent++;
    endtask

    // Stop offering and wait until every result has come back.
    task automatic drain();
        tx_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    // Write all registers, with junk in the unused upper bits and the spare index.
    task automatic set_config(input logic [tbrl_pkg::RATE_W-1:0]  rate,
                              input logic [tbrl_pkg::BURST_W-1:0] burst,
                              input logic [tbrl_pkg::TCAP_W-1:0]  tcap);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_SPARE;
        cfg_data <= {16'($urandom), $urandom};
        @(posedge clk);
        cfg_idx  <= tbrl_pkg::CFG_RATE;
        cfg_data <= {16'($urandom), rate};
        @(posedge clk);
        cfg_idx  <= tbrl_pkg::CFG_BURST;
        cfg_data <= {16'($urandom), burst};
        @(posedge clk);
        cfg_idx  <= tbrl_pkg::CFG_TOTAL_CAP;
        cfg_data <= tcap;
        @(posedge clk);
        cfg_we   <= 1'b0;
        settings++;
    endtask

    // Mostly steady time with small amounts, mixed with jumps, reversals and extremes.
    task automatic send_random();
        logic [tbrl_pkg::NOW_W-1:0] t;
        logic [tbrl_pkg::AMT_W-1:0] a;
        int pick;
        pick = $urandom_range(0, 99);
        t = stamp + tbrl_pkg::NOW_W'($urandom_range(0, 3000));
        a = $urandom_range(0, 8);
        if (pick >= 65 && pick < 77) begin
            t = stamp + tbrl_pkg::NOW_W'($urandom_range(0, 2000000));
            a = $urandom_range(0, 5000);
        end else if (pick >= 77 && pick < 82) begin
            a = $urandom;
        end else if (pick >= 82 && pick < 90) begin
            t = stamp - tbrl_pkg::NOW_W'($urandom_range(0, 5000));
        end else if (pick >= 90 && pick < 95) begin
            t = tbrl_pkg::NOW_W'({$urandom, $urandom});
        end else if (pick >= 95) begin
            t = stamp;
            a = $urandom_range(0, 1) ? AMT_MAX : '0;
        end
        stamp = t;
        send_item(t, a);
    endtask

    task automatic run_phase(input int p);
        logic [tbrl_pkg::RATE_W-1:0]  rate;
        logic [tbrl_pkg::BURST_W-1:0] burst;
        logic [tbrl_pkg::TCAP_W-1:0]  tcap;
        // Settle first so the cap is placed against the latest total.
        drain();
        case (p)
            0: begin rate = 1000; burst = 10; tcap = '0; end
            1: begin rate = RATE_MAX; burst = BURST_MAX; tcap = TCAP_MAX; end
            2: begin
                rate  = '0;
                burst = $urandom;
                tcap  = tbrl_pkg::TCAP_W'(last_total + $urandom_range(1, 300));
            end
            3: begin
                rate  = $urandom_range(1, 100);
                burst = $urandom_range(0, 20);
                tcap  = tbrl_pkg::TCAP_W'(last_total + $urandom_range(50, 400));
            end
            default: begin
                case ($urandom_range(0, 3))
                    0: rate = $urandom_range(1, 1000);
                    1: rate = $urandom_range(1, 2000000);
                    2: rate = $urandom;
                    default: rate = 1;
                endcase
                burst = $urandom_range(0, 1) ? $urandom_range(0, 50) : $urandom;
                tcap  = ($urandom_range(0, 2) == 0) ? '0 :
                        tbrl_pkg::TCAP_W'(last_total + $urandom_range(0, 1000));
            end
        endcase
        set_config(rate, burst, tcap);

        // Every third phase runs without idling; the last phase runs flat out.
        if (p == PHASES - 1) calm_tail = 1'b1;
        tx_idle_pct = (p % 3 == 1) ? 0 : 30;
        rx_idle_pct = (p % 3 == 1) ? 0 : 10;

        for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (p == PRESSURE_PHASE && i == 30) begin
                hold_len    = $urandom_range(300, 500);
                hold_req    = 1'b1;
                tx_idle_pct = 0;
            end
            send_random();
        end
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: no refill and no cap, so only the total and time stamp move.
        send_item('0, '0);
        send_item(NOW_MAX, AMT_MAX);
        send_item('0, 1);

        // Slowest rate: a huge forward jump is cut to an empty bucket, a huge
        // backward jump drives the balance to its most negative value.
        drain();
        set_config(1, '0, '0);
        send_item(NOW_MAX, '0);
        send_item('0, 1);
        send_item('0, '0);

        // Fastest rate and largest burst, with saturating gains both ways.
        drain();
        set_config(RATE_MAX, BURST_MAX, '0);
        send_item('0, '0);
        send_item(NOW_MAX, '0);
        send_item(NOW_MAX, AMT_MAX);
        send_item(1000, 5);

        // Rate set to zero: the balance freezes and no delay is given.
        drain();
        set_config('0, BURST_MAX, '0);
        send_item(5000, 7);
        send_item(4000, 3);

        // Refill resumes from the frozen balance.
        drain();
        set_config(1000000, 5, '0);
        send_item(6000, '0);
        send_item(NOW_MAX, 2);
        send_item(NOW_MAX, 10);

        // Smallest nonzero cap rejects, yet the bucket still updates.
        drain();
        set_config(7, 3, 1);
        send_item(NOW_MAX - 1, '0);
        send_item(NOW_MAX, 1);

        // Largest cap lets requests through again.
        drain();
        set_config(7, 3, TCAP_MAX);
        send_item(NOW_MAX, 4);
        send_item(100, '0);
        stamp = 100;

        for (int p = 0; p < PHASES; p++) run_phase(p);

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d requests over %0d register settings, with a long output hold-off.",
                 items_sent, settings);
        $display("Results: %0d in all, %0d with a delay, %0d rejected, %0d mismatches.",
                 results, delayed, rejects, mismatches);
        if (mismatches == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### token_bucket_rate_limiter.f
src/tbrl_pkg.sv
src/tbrl_front.sv
src/tbrl_fifo.sv
src/tbrl_back.sv
src/token_bucket_rate_limiter.sv
sim/token_bucket_rate_limiter_checker.sv
sim/token_bucket_rate_limiter_tb.sv
